// ----- rtl/core/osp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osp_pkg
// Shared types and constants of the operator scan list parser.
// ----------------------------------------------------------------------------
package osp_pkg;

  localparam int DEF_MAX_ENTRIES    = 16;
  localparam int DEF_LONG_NAME_LEN  = 20;
  localparam int DEF_SHORT_NAME_LEN = 20;

  localparam logic [4:0] ENTRY_LIMIT_RESET = 5'd16;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic FUNC_PARSE   = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  localparam logic [1:0] TERM_STATUS = 2'd0;
  localparam logic [1:0] TERM_LONG   = 2'd1;
  localparam logic [1:0] TERM_SHORT  = 2'd2;
  localparam logic [1:0] TERM_NUMBER = 2'd3;

  localparam logic KIND_LONG  = 1'b0;
  localparam logic KIND_SHORT = 1'b1;

  typedef struct packed {
    logic        name_write;
    logic        name_kind;
    logic [3:0]  entry_index;
    logic [4:0]  char_pos;
    logic [7:0]  char_value;
    logic        entry_done;
    logic [4:0]  entry_count;
    logic [7:0]  status_value;
    logic [31:0] operator_number;
    logic        stopped;
  } result_t;

endpackage

// ----- rtl/core/osp_parse_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osp_parse_core
// Parser state registers and the per-byte update logic that forms the result.
// ----------------------------------------------------------------------------
module osp_parse_core #(
  parameter int MAX_ENTRIES    = osp_pkg::DEF_MAX_ENTRIES,
  parameter int LONG_NAME_LEN  = osp_pkg::DEF_LONG_NAME_LEN,
  parameter int SHORT_NAME_LEN = osp_pkg::DEF_SHORT_NAME_LEN
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             func,
  input  logic [7:0]       char_in,
  input  logic [4:0]       entry_limit,
  output osp_pkg::result_t result
);
  import osp_pkg::*;

  localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int LIM_W    = (CNT_W > 5) ? CNT_W : 5;
  localparam int NAME_MAX = (LONG_NAME_LEN > SHORT_NAME_LEN) ? LONG_NAME_LEN : SHORT_NAME_LEN;
  localparam int POS_W    = $clog2(NAME_MAX);
  localparam int LEN_W    = POS_W + 1;

  localparam logic [LIM_W-1:0] MAX_LIM   = LIM_W'(MAX_ENTRIES);
  localparam logic [LEN_W-1:0] LONG_LIM  = LEN_W'(LONG_NAME_LEN);
  localparam logic [LEN_W-1:0] SHORT_LIM = LEN_W'(SHORT_NAME_LEN);
  localparam logic [35:0]      NUM_MAX   = 36'hFFFFFFFFF >> 4;

  logic             bracket_open, bracket_open_next;
  logic             double_comma, double_comma_next;
  logic [1:0]       term_number, term_number_next;
  logic [POS_W-1:0] term_position, term_position_next;
  logic [7:0]       previous_char, previous_char_next;
  logic [CNT_W-1:0] completed, completed_next;
  logic [7:0]       cur_status, cur_status_next;
  logic [31:0]      cur_number, cur_number_next;

  logic [LIM_W-1:0] limit_ext;
  logic [LIM_W-1:0] eff_limit;
  logic             halted;
  logic [11:0]      st_sum;
  logic [11:0]      st_diff;
  logic [7:0]       st_acc;
  logic [35:0]      num_sum;
  logic [35:0]      num_diff;
  logic [31:0]      num_acc;
  logic [LEN_W-1:0] name_len;
  logic [LEN_W-1:0] pos_inc;
  logic             done;

  assign limit_ext = LIM_W'(entry_limit);
  assign eff_limit = (limit_ext < MAX_LIM) ? limit_ext : MAX_LIM;
  assign halted    = double_comma || (LIM_W'(completed) >= eff_limit);

  // status term: 10 * value + byte - '0', clamped to 0..255
  assign st_sum  = 12'({cur_status, 3'b000}) + 12'({cur_status, 1'b0}) + 12'(char_in);
  assign st_diff = st_sum - 12'(CH_ZERO);
  assign st_acc  = (st_sum < 12'(CH_ZERO)) ? 8'd0 :
                   (st_diff > 12'd255)     ? 8'hFF : st_diff[7:0];

  // operator number term, clamped to 32 bits
  assign num_sum  = 36'({cur_number, 3'b000}) + 36'({cur_number, 1'b0}) + 36'(char_in);
  assign num_diff = num_sum - 36'(CH_ZERO);
  assign num_acc  = (num_sum < 36'(CH_ZERO)) ? 32'd0 :
                    (num_diff > NUM_MAX)     ? 32'hFFFF_FFFF : num_diff[31:0];

  assign name_len = (term_number == TERM_SHORT) ? SHORT_LIM : LONG_LIM;
  assign pos_inc  = LEN_W'(term_position) + LEN_W'(1);

  always_comb begin
    bracket_open_next  = bracket_open;
    double_comma_next  = double_comma;
    term_number_next   = term_number;
    term_position_next = term_position;
    previous_char_next = previous_char;
    completed_next     = completed;
    cur_status_next    = cur_status;
    cur_number_next    = cur_number;
    done               = 1'b0;
    result             = '0;
    result.entry_index = 4'(completed);

    if (func == FUNC_RESTART) begin
      bracket_open_next  = 1'b0;
      double_comma_next  = 1'b0;
      term_number_next   = TERM_STATUS;
      term_position_next = '0;
      previous_char_next = 8'd0;
      completed_next     = '0;
      cur_status_next    = 8'd0;
      cur_number_next    = 32'd0;
      result             = '0;
    end else begin
      if (!halted) begin
        previous_char_next = char_in;
        if (bracket_open) begin
          case (char_in)
            CH_CLOSE: begin
              bracket_open_next  = 1'b0;
              term_number_next   = TERM_STATUS;
              term_position_next = '0;
              completed_next     = completed + CNT_W'(1);
              cur_status_next    = 8'd0;
              cur_number_next    = 32'd0;
              done               = 1'b1;
            end
            CH_COMMA: begin
              term_number_next   = term_number + 2'd1;
              term_position_next = '0;
            end
            CH_QUOTE: begin
            end
            default: begin
              case (term_number)
                TERM_STATUS: cur_status_next = st_acc;
                TERM_NUMBER: cur_number_next = num_acc;
                default: begin
                  if (pos_inc < name_len) begin
                    result.name_write  = 1'b1;
                    result.name_kind   = (term_number == TERM_SHORT) ? KIND_SHORT : KIND_LONG;
                    result.char_pos    = 5'(term_position);
                    result.char_value  = char_in;
                    term_position_next = POS_W'(pos_inc);
                  end
                end
              endcase
            end
          endcase
        end else if (char_in == CH_OPEN) begin
          bracket_open_next = 1'b1;
        end else if (char_in == CH_COMMA && previous_char == CH_COMMA) begin
          double_comma_next = 1'b1;
        end
      end
      result.entry_done      = done;
      result.entry_count     = 5'(completed_next);
      result.status_value    = done ? cur_status : cur_status_next;
      result.operator_number = done ? cur_number : cur_number_next;
      result.stopped         = double_comma_next || (LIM_W'(completed_next) >= eff_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bracket_open  <= 1'b0;
      double_comma  <= 1'b0;
      term_number   <= TERM_STATUS;
      term_position <= '0;
      previous_char <= 8'd0;
      completed     <= '0;
      cur_status    <= 8'd0;
      cur_number    <= 32'd0;
    end else if (accept) begin
      bracket_open  <= bracket_open_next;
      double_comma  <= double_comma_next;
      term_number   <= term_number_next;
      term_position <= term_position_next;
      previous_char <= previous_char_next;
      completed     <= completed_next;
      cur_status    <= cur_status_next;
      cur_number    <= cur_number_next;
    end
  end

endmodule

// ----- rtl/core/osp_skid_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osp_skid_buf
// Two-entry result register that keeps input ready for one more result while the output stalls.
// ----------------------------------------------------------------------------
module osp_skid_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  osp_pkg::result_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output osp_pkg::result_t out_data
);
  import osp_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    push;
  logic    pop;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign push      = in_valid && in_ready;
  assign pop       = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop && push) begin
        main_valid <= 1'b1;
      end else if (pop) begin
        main_valid <= skid_valid;
        skid_valid <= 1'b0;
      end else if (push) begin
        if (main_valid) begin
          skid_valid <= 1'b1;
        end else begin
          main_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && push) begin
      main_data <= in_data;
    end else if (pop) begin
      main_data <= skid_data;
    end else if (push) begin
      if (main_valid) begin
        skid_data <= in_data;
      end else begin
        main_data <= in_data;
      end
    end
  end

endmodule

// ----- rtl/core/operator_scan_list_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// operator_scan_list_parser
// Byte-wise parser for a modem operator scan reply with one result per byte.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one transaction per reply byte: s_tdata is the byte, s_tuser
//   set means restart (state cleared, byte ignored). m_* returns one result
//   transaction per input: name table writes, entry completion, running
//   status and operator number, entry count and the halted flag.
//   cfg_wen/cfg_wdata set the entry limit; write it only while idle.
// Throughput:
//   one transaction per cycle while the result buffer has room; the result
//   is registered in the result buffer. The parser state updates in the
//   accepting cycle through the single state register loop.
// Reset:
//   rst clears parser state and result buffer; the entry limit returns to 16.
// Stall:
//   a two-entry result buffer keeps s_tready high for one extra transaction
//   while m_tready is low; after that s_tready drops until a result is taken.
// ----------------------------------------------------------------------------
module operator_scan_list_parser #(
  parameter int MAX_ENTRIES    = osp_pkg::DEF_MAX_ENTRIES,
  parameter int LONG_NAME_LEN  = osp_pkg::DEF_LONG_NAME_LEN,
  parameter int SHORT_NAME_LEN = osp_pkg::DEF_SHORT_NAME_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_in
  input  logic [0:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  // entry_index, char_pos, char_value, entry_count, status_value,
  // operator_number, stopped, zero pad
  output logic [63:0] m_tdata,
  output logic [2:0]  m_tuser,   // name_write, name_kind, entry_done
  input  logic        cfg_wen,
  input  logic [4:0]  cfg_wdata
);
  import osp_pkg::*;

  logic       entry_limit;
  logic [4:0] limit_reg;
  logic       in_accept;
  result_t    step_result;
  result_t    out_result;

  assign in_accept   = s_tvalid && s_tready;
  assign entry_limit = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= ENTRY_LIMIT_RESET;
    end else if (cfg_wen && entry_limit) begin
      limit_reg <= cfg_wdata;
    end
  end

  osp_parse_core #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .LONG_NAME_LEN  (LONG_NAME_LEN),
    .SHORT_NAME_LEN (SHORT_NAME_LEN)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .func        (s_tuser[0]),
    .char_in     (s_tdata),
    .entry_limit (limit_reg),
    .result      (step_result)
  );

  osp_skid_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (step_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tuser = {out_result.entry_done, out_result.name_kind, out_result.name_write};
  assign m_tdata = {1'b0,
                    out_result.stopped,
                    out_result.operator_number,
                    out_result.status_value,
                    out_result.entry_count,
                    out_result.char_value,
                    out_result.char_pos,
                    out_result.entry_index};

  // a completed entry never carries a name write
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> !m_tuser[0])
    else $error("entry completion together with name write");

  // completion bumps the count to one past the completed index
  assert property (@(posedge clk) disable iff (rst)
    in_accept && step_result.entry_done |->
      step_result.entry_count[3:0] == step_result.entry_index + 4'd1)
    else $error("entry count does not follow completed index");

  // a name write only happens while parsing is live
  assert property (@(posedge clk) disable iff (rst)
    in_accept && step_result.name_write |-> !step_result.stopped)
    else $error("name write reported while halted");

  // input back-pressure only with a result waiting
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty result buffer");

endmodule

// ----- tb/sv/operator_scan_list_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// operator_scan_list_parser_tb
// Self-checking bench for the operator scan list parser. Reply bytes and
// restarts are queued by a stimulus process and sent by a clocked driver with
// random gaps in most phases; every accepted byte is run through a local
// parser model and the expected result is queued. A clocked monitor with
// random back pressure in most phases compares each result transaction field
// by field. The entry limit is set between phases while the parser is idle,
// covering zero, one, full table and out-of-range values.
// ----------------------------------------------------------------------------
module operator_scan_list_parser_tb;
  import osp_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 110;
  localparam int END_WAIT     = 10;

  typedef struct packed {
    logic       func;
    logic [7:0] char_in;
  } scan_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_wen = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  scan_byte_t  pending_bytes[$];
  result_t     expected_results[$];
  scan_byte_t  next_byte;
  result_t     seen_result;
  int          send_gap = 0;
  int          ready_stall = 0;
  bit          send_idle_on = 1'b1;
  bit          ready_idle_on = 1'b1;
  int          mismatch_count = 0;
  int          result_count = 0;
  int unsigned cycle_count = 0;
  int          phase_items = 0;

  // parser model state
  logic [4:0]  limit_reg = ENTRY_LIMIT_RESET;
  logic        in_bracket = 1'b0;
  logic        dbl_comma = 1'b0;
  logic [1:0]  term_idx = '0;
  logic [4:0]  term_pos = '0;
  logic [7:0]  prev_ch = '0;
  logic [4:0]  done_count = '0;
  logic [7:0]  cur_status = '0;
  logic [31:0] cur_number = '0;

  operator_scan_list_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic bit parser_halted();
    int lim;
    lim = (int'(limit_reg) < DEF_MAX_ENTRIES) ? int'(limit_reg) : DEF_MAX_ENTRIES;
    return dbl_comma || (int'(done_count) >= lim);
  endfunction

  function automatic result_t predict_scan_result(logic func, logic [7:0] ch);
    result_t r;
    int      sv;
    longint  nv;
    int      len;
    r = '0;
    if (func == FUNC_RESTART) begin
      in_bracket = 1'b0;
      dbl_comma  = 1'b0;
      term_idx   = '0;
      term_pos   = '0;
      prev_ch    = '0;
      done_count = '0;
      cur_status = '0;
      cur_number = '0;
      return r;
    end
    r.status_value    = cur_status;
    r.operator_number = cur_number;
    if (!parser_halted()) begin
      if (in_bracket) begin
        if (ch == CH_CLOSE) begin
          r.entry_done  = 1'b1;
          r.entry_index = done_count[3:0];
          in_bracket = 1'b0;
          term_idx   = '0;
          term_pos   = '0;
          done_count = done_count + 5'd1;
          cur_status = '0;
          cur_number = '0;
        end else if (ch == CH_COMMA) begin
          term_idx = term_idx + 2'd1;
          term_pos = '0;
        end else if (ch != CH_QUOTE) begin
          if (term_idx == TERM_STATUS) begin
            sv = 10 * int'(cur_status) + int'(ch) - int'(CH_ZERO);
            if (sv < 0) sv = 0;
            if (sv > 255) sv = 255;
            cur_status = sv[7:0];
          end else if (term_idx == TERM_NUMBER) begin
            nv = {32'b0, cur_number};
            nv = nv * 10 + longint'(int'(ch) - int'(CH_ZERO));
            if (nv < 0) nv = 0;
            if (nv > 64'h0000_0000_FFFF_FFFF) nv = 64'h0000_0000_FFFF_FFFF;
            cur_number = nv[31:0];
          end else begin
            len = (term_idx == TERM_LONG) ? DEF_LONG_NAME_LEN : DEF_SHORT_NAME_LEN;
            if (int'(term_pos) + 1 < len) begin
              r.name_write = 1'b1;
              r.name_kind  = (term_idx == TERM_SHORT) ? KIND_SHORT : KIND_LONG;
              r.char_pos   = term_pos;
              r.char_value = ch;
              term_pos = term_pos + 5'd1;
            end
          end
          r.status_value    = cur_status;
          r.operator_number = cur_number;
        end
      end else begin
        if (ch == CH_OPEN) in_bracket = 1'b1;
        else if (ch == CH_COMMA && prev_ch == CH_COMMA) dbl_comma = 1'b1;
      end
      prev_ch = ch;
    end
    if (!r.entry_done) r.entry_index = done_count[3:0];
    r.entry_count = done_count;
    r.stopped     = parser_halted();
    return r;
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] exp_v);
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             result_count, what, got_v, exp_v);
    mismatch_count++;
  endtask

  task automatic check_scan_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected transaction", 32'(got.entry_count), 32'd0);
      return;
    end
    want = expected_results.pop_front();
    if (got.name_write !== want.name_write)
      report_mismatch("name_write", 32'(got.name_write), 32'(want.name_write));
    if (got.name_kind !== want.name_kind)
      report_mismatch("name_kind", 32'(got.name_kind), 32'(want.name_kind));
    if (got.entry_index !== want.entry_index)
      report_mismatch("entry_index", 32'(got.entry_index), 32'(want.entry_index));
    if (got.char_pos !== want.char_pos)
      report_mismatch("char_pos", 32'(got.char_pos), 32'(want.char_pos));
    if (got.char_value !== want.char_value)
      report_mismatch("char_value", 32'(got.char_value), 32'(want.char_value));
    if (got.entry_done !== want.entry_done)
      report_mismatch("entry_done", 32'(got.entry_done), 32'(want.entry_done));
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
    if (got.status_value !== want.status_value)
      report_mismatch("status_value", 32'(got.status_value), 32'(want.status_value));
    if (got.operator_number !== want.operator_number)
      report_mismatch("operator_number", got.operator_number, want.operator_number);
    if (got.stopped !== want.stopped)
      report_mismatch("stopped", 32'(got.stopped), 32'(want.stopped));
  endtask

  // driver: predict on acceptance, then load the next queued byte
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_results.push_back(predict_scan_result(s_tuser[0], s_tdata));
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          next_byte = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_byte.char_in;
          s_tuser  <= next_byte.func;
          send_gap <= send_idle_on ? pick_gap() : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor with random back pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      ready_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_result.entry_index     = m_tdata[3:0];
        seen_result.char_pos        = m_tdata[8:4];
        seen_result.char_value      = m_tdata[16:9];
        seen_result.entry_count     = m_tdata[21:17];
        seen_result.status_value    = m_tdata[29:22];
        seen_result.operator_number = m_tdata[61:30];
        seen_result.stopped         = m_tdata[62];
        seen_result.name_write      = m_tuser[0];
        seen_result.name_kind       = m_tuser[1];
        seen_result.entry_done      = m_tuser[2];
        check_scan_result(seen_result);
        result_count++;
      end
      if (ready_stall > 0) begin
        ready_stall <= ready_stall - 1;
        m_tready    <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (ready_idle_on && $urandom_range(0, 3) == 0) ready_stall <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_byte(input logic func, input logic [7:0] ch);
    scan_byte_t b;
    b.func    = func;
    b.char_in = ch;
    pending_bytes.push_back(b);
    phase_items++;
  endtask

  task automatic push_char(input logic [7:0] ch);
    push_byte(FUNC_PARSE, ch);
  endtask

  task automatic push_restart();
    push_byte(FUNC_RESTART, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_name_byte();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255));
    while (ch == CH_COMMA || ch == CH_CLOSE || ch == CH_QUOTE);
    return ch;
  endfunction

  task automatic push_decimal(input int max_len);
    int n;
    n = $urandom_range(0, max_len);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) != 0) push_char(CH_ZERO + 8'($urandom_range(0, 9)));
      else if ($urandom_range(0, 3) == 0) push_char(CH_QUOTE);
      else push_char(pick_name_byte());
    end
  endtask

  task automatic push_name();
    int n;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 12);
    push_char(CH_QUOTE);
    for (int i = 0; i < n; i++) push_char(pick_name_byte());
    push_char(CH_QUOTE);
  endtask

  // reply of (status,"long","short",number) entries, not always well-formed
  task automatic push_scan_reply(input int entries);
    for (int k = 0; k < entries; k++) begin
      if (k > 0) push_char(CH_COMMA);
      push_char(CH_OPEN);
      push_decimal(4);
      push_char(CH_COMMA);
      push_name();
      push_char(CH_COMMA);
      push_name();
      push_char(CH_COMMA);
      push_decimal(($urandom_range(0, 5) == 0) ? 13 : 6);
      if ($urandom_range(0, 9) == 0) begin
        push_char(CH_COMMA);
        push_decimal(3);
      end
      push_char(CH_CLOSE);
    end
    if ($urandom_range(0, 1) == 0) begin
      push_char(CH_COMMA);
      push_char(CH_COMMA);
    end
    if ($urandom_range(0, 2) == 0) push_char(8'($urandom_range(0, 255)));
  endtask

  task automatic push_noise();
    int n;
    n = $urandom_range(3, 15);
    if ($urandom_range(0, 1) == 0) push_char(CH_OPEN);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) push_restart();
      else push_char(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_for_idle();
    @(negedge clk);
    while (pending_bytes.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_entry_limit(input logic [4:0] value);
    wait_for_idle();
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    limit_reg = value;
  endtask

  logic [4:0] phase_limits[8] = '{5'd16, 5'd0, 5'd1, 5'd3, 5'd31, 5'd2, 5'd16, 5'd9};

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: saturation both ways, both names, close, double comma, halted byte
    push_byte(FUNC_RESTART, 8'hFF);
    push_char(CH_OPEN);
    push_char(8'h00);
    push_char(8'hFF);
    push_char(CH_ZERO + 8'd2);
    push_char(CH_COMMA);
    push_char(CH_QUOTE);
    push_char(8'h00);
    push_char(8'hFF);
    push_char(CH_QUOTE);
    push_char(CH_COMMA);
    push_char(CH_QUOTE);
    push_char(8'h78);
    push_char(CH_QUOTE);
    push_char(CH_COMMA);
    push_char(CH_ZERO + 8'd9);
    push_char(CH_ZERO + 8'd9);
    push_char(8'hFF);
    push_char(CH_CLOSE);
    push_char(CH_COMMA);
    push_char(CH_COMMA);
    push_char(8'h41);
    push_byte(FUNC_RESTART, 8'h00);

    for (int p = 0; p < 8; p++) begin
      write_entry_limit((p == 7) ? 5'($urandom_range(0, 31)) : phase_limits[p]);
      send_idle_on  = (p % 3 != 2);
      ready_idle_on = (p % 4 != 3);
      phase_items = 0;
      push_restart();
      while (phase_items < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: begin
            push_scan_reply(($urandom_range(0, 7) == 0) ? $urandom_range(14, 18)
                                                         : $urandom_range(1, 5));
            push_restart();
          end
          7, 8: push_noise();
          default: push_restart();
        endcase
        if (p == 3 && phase_items > PHASE_ITEMS / 2 && phase_items < PHASE_ITEMS / 2 + 60)
          wait_for_idle();
      end
    end

    wait_for_idle();
    repeat (END_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
